>>> rtl/biquad_cascade_iir_filter_macros.svh
// Assertion macros shared by the filter RTL.
// BQC_ASSERT_IMP  : a holds now, so b holds in the same cycle.
// BQC_ASSERT_NEXT : a holds now, so b holds in the next cycle.
`ifndef BIQUAD_CASCADE_IIR_FILTER_MACROS_SVH
`define BIQUAD_CASCADE_IIR_FILTER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BQC_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define BQC_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define BQC_ASSERT_IMP(label, clk, rst_n, a, b)
`define BQC_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

>>> rtl/bqc_pkg.sv
package bqc_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_SECTIONS_DEF = 4;
  localparam int COEF_BITS_DEF    = 16;

  // Fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int DATA_W   = 32;   // Q16.16 signals and history
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 3;
  localparam int LANE_W   = 16;   // one coefficient lane in a packed register
  localparam int COUNT_W  = 3;
  // Exact sum of x*2^F and three 16x32 products fits in 50 bits
  localparam int ACC_W    = 50;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SECTION_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM0          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM1          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NUM2          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEN1          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEN2          = 3'd5;

  typedef logic signed [DATA_W-1:0]   data_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  localparam data_t DATA_MAX = 32'sh7fff_ffff;
  localparam data_t DATA_MIN = 32'sh8000_0000;

endpackage

>>> rtl/biquad_cascade_iir_filter.sv
// Channel   Signals                           Direction  Moves
// in        in_valid/in_ready, in_sample_in   input      one Q0 16-bit sample
// out       out_valid/out_ready, out_*        output     filtered sample + clip flag
// cfg       cfg_we, cfg_index, cfg_data       input      register write, no wait
//
// An item walks the row of section cells: each active cell steps through its
// states (five products on its own 16x32 multiplier plus rounding), an inactive
// one forwards it unchanged through its output register.
// One item is in the row at a time; in_ready rises again once the result has
// moved into the output register, which may still wait for out_ready.
// Synchronous active-low reset clears control state, config registers and history.
`include "biquad_cascade_iir_filter_macros.svh"

module biquad_cascade_iir_filter import bqc_pkg::*; #(
  parameter int MAX_SECTIONS = MAX_SECTIONS_DEF,
  parameter int COEF_BITS    = COEF_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sample_t              in_sample_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sample_t              out_sample_out,
  output logic                 out_saturated,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [COUNT_W-1:0] section_count_r;
  logic [CFG_W-1:0]   num0_r, num1_r, num2_r, den1_r, den2_r;

  logic               busy_r;
  logic               fin_valid_r;
  data_t              fin_y_r;
  logic               out_valid_r;
  sample_t            out_sample_r;
  logic               out_sat_r;

  logic [COUNT_W-1:0] count_eff;
  logic               in_xfer;
  logic               fin_move;

  logic  [MAX_SECTIONS:0] stage_go;
  data_t                  stage_x [MAX_SECTIONS+1];

  logic signed [DATA_W:0]     fsum;
  logic signed [SAMPLE_W:0]   fq;
  logic                       fsat;
  sample_t                    fsample;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      section_count_r <= '0;
      num0_r          <= '0;
      num1_r          <= '0;
      num2_r          <= '0;
      den1_r          <= '0;
      den2_r          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SECTION_COUNT: section_count_r <= cfg_data[COUNT_W-1:0];
        REG_NUM0:          num0_r          <= cfg_data;
        REG_NUM1:          num1_r          <= cfg_data;
        REG_NUM2:          num2_r          <= cfg_data;
        REG_DEN1:          den1_r          <= cfg_data;
        REG_DEN2:          den2_r          <= cfg_data;
        default: ;
      endcase
    end
  end

  // Counts above the cell row act as a full row
  assign count_eff = (section_count_r > COUNT_W'(MAX_SECTIONS)) ?
                     COUNT_W'(MAX_SECTIONS) : section_count_r;

  assign in_ready = !busy_r;
  assign in_xfer  = in_valid && !busy_r;
  assign fin_move = fin_valid_r && (!out_valid_r || out_ready);

  assign stage_go[0] = in_xfer;
  assign stage_x[0]  = data_t'(in_sample_in) <<< 16;

  // Row of section cells
  for (genvar i = 0; i < MAX_SECTIONS; i++) begin : g_cell
    bqc_cell #(
      .COEF_BITS (COEF_BITS)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .start  (stage_go[i]),
      .active (COUNT_W'(i) < count_eff),
      .x_in   (stage_x[i]),
      .b0     ($signed(num0_r[LANE_W*i +: COEF_BITS])),
      .b1     ($signed(num1_r[LANE_W*i +: COEF_BITS])),
      .b2     ($signed(num2_r[LANE_W*i +: COEF_BITS])),
      .a1     ($signed(den1_r[LANE_W*i +: COEF_BITS])),
      .a2     ($signed(den2_r[LANE_W*i +: COEF_BITS])),
      .done   (stage_go[i+1]),
      .y_out  (stage_x[i+1])
    );
  end

  // Final rounding to 16 bits with clip
  assign fsum    = (DATA_W+1)'(fin_y_r) + (DATA_W+1)'(32768);
  assign fq      = fsum[DATA_W:DATA_W-SAMPLE_W];
  assign fsat    = fq[SAMPLE_W] != fq[SAMPLE_W-1];
  assign fsample = fsat ? (fq[SAMPLE_W] ? 16'sh8000 : 16'sh7fff) : fq[SAMPLE_W-1:0];

  // Item tracking, pending result and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy_r <= 1'b1;
      end else if (fin_move) begin
        busy_r <= 1'b0;
      end
      if (stage_go[MAX_SECTIONS]) begin
        fin_valid_r <= 1'b1;
      end else if (fin_move) begin
        fin_valid_r <= 1'b0;
      end
      if (fin_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go[MAX_SECTIONS]) begin
      fin_y_r <= stage_x[MAX_SECTIONS];
    end
    if (fin_move) begin
      out_sample_r <= fsample;
      out_sat_r    <= fsat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_saturated  = out_sat_r;

  `BQC_ASSERT_IMP(a_fin_while_busy, clk, rst_n, fin_valid_r, busy_r)
  `BQC_ASSERT_IMP(a_done_while_busy, clk, rst_n, stage_go[MAX_SECTIONS], busy_r && !fin_valid_r)
  `BQC_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_xfer, busy_r && !in_ready)

endmodule

>>> rtl/bqc_cell.sv
`include "biquad_cascade_iir_filter_macros.svh"

// One direct-form-II biquad section. Holds its own w1/w2 history and
// runs five multiplies through one shared 16x32 multiplier.
module bqc_cell import bqc_pkg::*; #(
  parameter int COEF_BITS = COEF_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        active,
  input  data_t                       x_in,
  input  logic signed [COEF_BITS-1:0] b0,
  input  logic signed [COEF_BITS-1:0] b1,
  input  logic signed [COEF_BITS-1:0] b2,
  input  logic signed [COEF_BITS-1:0] a1,
  input  logic signed [COEF_BITS-1:0] a2,
  output logic                        done,
  output data_t                       y_out
);

  localparam int FRAC   = COEF_BITS - 2;
  localparam int PROD_W = COEF_BITS + DATA_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_A2   = 3'd1;
  localparam logic [2:0] ST_W    = 3'd2;
  localparam logic [2:0] ST_B2   = 3'd3;
  localparam logic [2:0] ST_B0   = 3'd4;
  localparam logic [2:0] ST_Y    = 3'd5;

  logic [2:0] state_r, state_nxt;
  acc_t       acc_r, acc_nxt;
  data_t      w_r, w_nxt;
  data_t      w1_r, w1_nxt;
  data_t      w2_r, w2_nxt;
  data_t      y_r, y_nxt;
  logic       done_r, done_nxt;

  logic signed [COEF_BITS-1:0] mul_coef;
  data_t                       mul_data;
  logic signed [PROD_W-1:0]    prod;
  acc_t                        prod_ext;
  acc_t                        x_shift;
  data_t                       acc_round;

  // Round half up by F bits, then clip to Q16.16
  function automatic data_t round_q(input acc_t a);
    logic signed [ACC_W:0] s;
    logic signed [ACC_W:0] q;
    s = (ACC_W+1)'(a) + ((ACC_W+1)'(1) <<< (FRAC - 1));
    q = s >>> FRAC;
    if (q > (ACC_W+1)'(DATA_MAX)) begin
      return DATA_MAX;
    end else if (q < (ACC_W+1)'(DATA_MIN)) begin
      return DATA_MIN;
    end else begin
      return $signed(q[DATA_W-1:0]);
    end
  endfunction

  // Multiplier operand select
  always_comb begin
    unique case (state_r)
      ST_A2: begin
        mul_coef = a2;
        mul_data = w2_r;
      end
      ST_W: begin
        mul_coef = b1;
        mul_data = w1_r;
      end
      ST_B2: begin
        mul_coef = b2;
        mul_data = w2_r;
      end
      ST_B0: begin
        mul_coef = b0;
        mul_data = w_r;
      end
      default: begin
        mul_coef = a1;
        mul_data = w1_r;
      end
    endcase
  end

  assign prod      = mul_coef * mul_data;
  assign prod_ext  = ACC_W'(prod);
  assign x_shift   = ACC_W'(x_in) <<< FRAC;
  assign acc_round = round_q(acc_r);

  // Section sequencer
  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    w_nxt     = w_r;
    w1_nxt    = w1_r;
    w2_nxt    = w2_r;
    y_nxt     = y_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start && active) begin
          acc_nxt   = x_shift - prod_ext;
          state_nxt = ST_A2;
        end else if (start) begin
          // inactive section: hand the sample on unchanged
          y_nxt    = x_in;
          done_nxt = 1'b1;
        end
      end
      ST_A2: begin
        acc_nxt   = acc_r - prod_ext;
        state_nxt = ST_W;
      end
      ST_W: begin
        w_nxt     = acc_round;
        acc_nxt   = prod_ext;
        state_nxt = ST_B2;
      end
      ST_B2: begin
        acc_nxt   = acc_r + prod_ext;
        state_nxt = ST_B0;
      end
      ST_B0: begin
        acc_nxt   = acc_r + prod_ext;
        state_nxt = ST_Y;
      end
      ST_Y: begin
        y_nxt     = acc_round;
        w2_nxt    = w1_r;
        w1_nxt    = w_r;
        done_nxt  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
      w1_r    <= '0;
      w2_r    <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      w1_r    <= w1_nxt;
      w2_r    <= w2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    w_r   <= w_nxt;
    y_r   <= y_nxt;
  end

  assign done  = done_r;
  assign y_out = y_r;

  `BQC_ASSERT_IMP(a_start_when_idle, clk, rst_n, start, state_r == ST_IDLE)
  `BQC_ASSERT_NEXT(a_active_runs, clk, rst_n, start && active, state_r == ST_A2)
  `BQC_ASSERT_NEXT(a_history_holds, clk, rst_n, state_r != ST_Y, $stable(w1_r) && $stable(w2_r))

endmodule
